// ----- rtl/class_pattern_dictionary_match_count_defines.svh -----
// Assertion macros for the class pattern dictionary match counter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CLASS_PATTERN_DICTIONARY_MATCH_COUNT_DEFINES_SVH
`define CLASS_PATTERN_DICTIONARY_MATCH_COUNT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define CPDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpdm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpdm assertion failed");

`else

`define CPDM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPDM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/cpdm_pkg.sv -----
// Shared widths and codes for the class pattern dictionary match counter.
// No dependencies.
`default_nettype none

package cpdm_pkg;

  // Field widths of the stream payloads and the length register.
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned MASK_W   = 26;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned OUT_W    = 13;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  // Item kinds carried on tuser.
  typedef logic [0:0] func_t;
  localparam func_t FUNC_LETTER = 1'b0;
  localparam func_t FUNC_CLASS  = 1'b1;

  // Reset value of the word length register.
  localparam logic [CFG_W-1:0] WORD_LEN_RESET = 5'd15;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [MASK_W-1:0]   mask_t;

endpackage

`default_nettype wire

// ----- rtl/class_pattern_dictionary_match_count.sv -----
// A letter is written to the dictionary at its input transfer; a final pattern position's result
// is loaded into the output register once the sweep is done and that register is free.
// Letters are accepted back to back while idle; a pattern position holds in_tready low while
// one word per cycle passes through the shared letter-test unit, then for the read, drain and
// finish steps; a waiting result stretches this.
// Reset (rst_n, synchronous, active low) clears counters, sets word_length to 15, no memory clear.
`default_nettype none

`include "class_pattern_dictionary_match_count_defines.svh"

module class_pattern_dictionary_match_count
  import cpdm_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 4096,
  parameter int unsigned MAX_LEN   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration: word_length.
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  // Input stream. tdata: letter [4:0], class_mask [30:5], zero [31].
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: func [0].
  input  wire logic [0:0]             in_tuser,
  // Result stream. tdata: match_count [12:0], zero [15:13].
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // Derived sizes.
  localparam int unsigned WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DICT_DEPTH = 1 << (WW + PW);

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;

  // Memories.
  letter_t dict_mem  [DICT_DEPTH];
  logic    alive_mem [1 << WW];

  // Control and data registers.
  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] len_cfg_r;
  logic [CW-1:0]    stored_r, stored_nxt;
  logic [PW-1:0]    load_pos_r, load_pos_nxt;
  logic [PW-1:0]    pat_pos_r, pat_pos_nxt;
  logic [PW-1:0]    cur_pos_r, cur_pos_nxt;
  logic             first_r, first_nxt;
  logic             last_r, last_nxt;
  mask_t            mask_r, mask_nxt;
  logic [CW-1:0]    iss_r, iss_nxt;
  logic             pv_r, pv_nxt;
  logic [WW-1:0]    pidx_r, pidx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  letter_t          letter_q_r;
  logic             alive_q_r;

  // Unpacked input fields.
  func_t   in_func;
  letter_t in_letter;
  mask_t   in_mask;
  logic    in_xfer;

  // Memory write controls.
  logic          dict_we;
  logic          am_we;
  logic [WW-1:0] am_waddr;
  logic          am_wdata;

  // Effective length and helpers.
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  load_inc;
  logic [LEN_W-1:0]  pat_inc;
  logic              issue;
  logic [31:0]       mask_ext;
  logic              hit;
  logic              new_flag;

  assign in_func   = in_tuser;
  assign in_letter = in_tdata[LETTER_W-1:0];
  assign in_mask   = in_tdata[LETTER_W+MASK_W-1:LETTER_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data_r};

  // Word length as used: zero counts as one, large values cap at MAX_LEN.
  always_comb begin
    if (len_cfg_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(len_cfg_r) > LEN_W'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = LEN_W'(len_cfg_r);
    end
  end

  assign load_inc = LEN_W'(load_pos_r) + LEN_W'(1);
  assign pat_inc  = LEN_W'(pat_pos_r) + LEN_W'(1);

  // Shared letter-test unit: one stored word per cycle.
  assign issue    = (state_r == ST_SWEEP) && (iss_r < stored_r);
  assign mask_ext = {{(32-MASK_W){1'b0}}, mask_r};
  assign hit      = mask_ext[letter_q_r];
  assign new_flag = (first_r | alive_q_r) & hit;

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    stored_nxt    = stored_r;
    load_pos_nxt  = load_pos_r;
    pat_pos_nxt   = pat_pos_r;
    cur_pos_nxt   = cur_pos_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    mask_nxt      = mask_r;
    iss_nxt       = iss_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    dict_we       = 1'b0;
    am_we         = 1'b0;
    am_waddr      = pidx_r;
    am_wdata      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_LETTER) begin
            // Append a letter unless the dictionary is full.
            if (stored_r < CW'(MAX_WORDS)) begin
              dict_we = 1'b1;
              if (load_inc >= eff_len) begin
                am_we        = 1'b1;
                am_waddr     = stored_r[WW-1:0];
                am_wdata     = 1'b0;
                stored_nxt   = stored_r + CW'(1);
                load_pos_nxt = '0;
              end else begin
                load_pos_nxt = load_inc[PW-1:0];
              end
            end
          end else begin
            // Start a sweep over the stored words for this position.
            mask_nxt    = in_mask;
            cur_pos_nxt = pat_pos_r;
            first_nxt   = (pat_pos_r == '0);
            last_nxt    = (pat_inc >= eff_len);
            pat_pos_nxt = (pat_inc >= eff_len) ? '0 : pat_inc[PW-1:0];
            iss_nxt     = '0;
            cnt_nxt     = '0;
            state_nxt   = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (issue) begin
          pv_nxt   = 1'b1;
          pidx_nxt = iss_r[WW-1:0];
          iss_nxt  = iss_r + CW'(1);
        end
        if (pv_r) begin
          am_we    = 1'b1;
          am_waddr = pidx_r;
          am_wdata = new_flag;
          cnt_nxt  = cnt_r + CW'(new_flag);
        end
        if (!issue && !pv_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // A non-final position returns to idle; a final one hands the count to the output register once it is free.
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_cfg_r   <= WORD_LEN_RESET;
      stored_r    <= '0;
      load_pos_r  <= '0;
      pat_pos_r   <= '0;
      iss_r       <= '0;
      pv_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stored_r    <= stored_nxt;
      load_pos_r  <= load_pos_nxt;
      pat_pos_r   <= pat_pos_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        len_cfg_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_pos_r  <= cur_pos_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    mask_r     <= mask_nxt;
    pidx_r     <= pidx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Dictionary memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[{stored_r[WW-1:0], load_pos_r}] <= in_letter;
    end
    letter_q_r <= dict_mem[{iss_r[WW-1:0], cur_pos_r}];
  end

  // Alive-flag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (am_we) begin
      alive_mem[am_waddr] <= am_wdata;
    end
    alive_q_r <= alive_mem[iss_r[WW-1:0]];
  end

  // Checks on the sweep sequencer.
  `CPDM_ASSERT_IMP(a_store_bound, clk, rst_n, 1'b1, stored_r <= CW'(MAX_WORDS))
  `CPDM_ASSERT_IMP(a_sweep_idx, clk, rst_n, pv_r, {{(CW-WW){1'b0}}, pidx_r} < stored_r)
  `CPDM_ASSERT_IMP(a_cnt_bound, clk, rst_n, state_r == ST_SWEEP, cnt_r <= iss_r)
  `CPDM_ASSERT_IMP(a_fin_done, clk, rst_n, state_r == ST_FIN, iss_r == stored_r && !pv_r)
  `CPDM_ASSERT_NXT(a_fin_idle, clk, rst_n, state_r == ST_FIN && !last_r, state_r == ST_IDLE)

endmodule

`default_nettype wire

// ----- sim/match_count_checker.sv -----
// Checker for the class pattern dictionary match counter: watches the configuration
// port and both stream channels, predicts every match count and compares the results.
// Depends on cpdm_pkg for widths, item kinds and the word length reset value.
`default_nettype none

module match_count_checker
  import cpdm_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 4096,
  parameter int unsigned MAX_LEN   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // tdata: letter [4:0], class_mask [30:5], zero [31].
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: func [0].
  input  wire logic [0:0]             in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // tdata: match_count [12:0], zero [15:13].
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  output int                          counts_awaited,
  output int                          mismatch_count
);

  // Shadow copy of the dictionary, the alive flags and the counters.
  letter_t          dict_letters [MAX_WORDS*MAX_LEN];
  bit               alive [MAX_WORDS];
  int unsigned      words_stored;
  int unsigned      load_pos;
  int unsigned      pattern_pos;
  logic [CFG_W-1:0] word_length;

  // Match counts predicted at input transfers, oldest first.
  logic [OUT_W-1:0] pending_match_counts [$];

  always @(posedge clk) begin : predict_and_compare
    int unsigned      len;
    int unsigned      pos;
    int unsigned      hits;
    int unsigned      w;
    letter_t          ch;
    mask_t            cls;
    logic             hit;
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      word_length    = WORD_LEN_RESET;
      words_stored   = 0;
      load_pos       = 0;
      pattern_pos    = 0;
      mismatch_count = 0;
      pending_match_counts.delete();
    end else begin
      if (cfg_wr_en) begin
        word_length = cfg_wr_data;
      end

      // Input transfer: store a letter or apply one pattern position.
      if (in_tvalid && in_tready) begin
        len = (word_length == 0) ? 1 : ((word_length > MAX_LEN) ? MAX_LEN : word_length);
        ch  = in_tdata[LETTER_W-1:0];
        cls = in_tdata[LETTER_W +: MASK_W];
        if (in_tuser == FUNC_LETTER) begin
          // Letters are dropped once the dictionary is full.
          if (words_stored < MAX_WORDS) begin
            if (load_pos < MAX_LEN) begin
              dict_letters[words_stored*MAX_LEN + load_pos] = ch;
            end
            load_pos++;
            if (load_pos >= len) begin
              // A word that completes mid-pattern does not count for that pattern.
              alive[words_stored] = 1'b0;
              words_stored++;
              load_pos = 0;
            end
          end
        end else begin
          pos = (pattern_pos < MAX_LEN) ? pattern_pos : MAX_LEN - 1;
          for (w = 0; w < words_stored; w++) begin
            ch  = dict_letters[w*MAX_LEN + pos];
            hit = (ch < MASK_W) ? cls[ch] : 1'b0;
            // The first position of a pattern ignores earlier flags.
            alive[w] = hit && (pattern_pos == 0 || alive[w]);
          end
          pattern_pos++;
          if (pattern_pos >= len) begin
            hits = 0;
            for (w = 0; w < words_stored; w++) begin
              hits += alive[w];
            end
            pattern_pos = 0;
            pending_match_counts.insert(pending_match_counts.size(), OUT_W'(hits));
          end
        end
      end

      // Output transfer: compare with the oldest predicted count.
      if (out_tvalid && out_tready) begin
        if (pending_match_counts.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: match count %0d arrived with none predicted",
                     $realtime, out_tdata[OUT_W-1:0]);
          end
          mismatch_count++;
        end else begin
          want = pending_match_counts.pop_front();
          if (out_tdata !== {{(OUT_TDATA_W-OUT_W){1'b0}}, want}) begin
            if (mismatch_count < 10) begin
              $display("%0t: match count mismatch, expected %0d, got tdata 0x%0h",
                       $realtime, want, out_tdata);
            end
            mismatch_count++;
          end
        end
      end
    end
    counts_awaited = pending_match_counts.size();
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Top of the simulation for the class pattern dictionary match counter: clock, reset,
// stimulus for the letter/pattern stream, random result backpressure and the verdict.
// Depends on cpdm_pkg, the block itself and match_count_checker.
`default_nettype none

module testbench;
  import cpdm_pkg::*;

  localparam int unsigned MAX_WORDS     = 4096;
  localparam int unsigned MAX_LEN       = 16;
  localparam int unsigned SETTLE_CYCLES = MAX_WORDS + 8;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam mask_t       ALL_LETTERS   = {MASK_W{1'b1}};

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [0:0]             in_tuser    = FUNC_LETTER;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     counts_awaited;
  int                     mismatch_count;

  // Stimulus bookkeeping: effective length, pattern position and progress counters.
  int unsigned cycle_count   = 0;
  int unsigned cur_len       = 15;
  int unsigned pat_pos       = 0;
  int unsigned items_sent    = 0;
  int unsigned patterns_done = 0;

  always #6 clk = ~clk;

  class_pattern_dictionary_match_count #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_LEN   (MAX_LEN)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  match_count_checker #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_LEN   (MAX_LEN)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .counts_awaited (counts_awaited),
    .mismatch_count (mismatch_count)
  );

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Letters favor a small alphabet so that words share letters and patterns match.
  function automatic letter_t next_letter();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return letter_t'($urandom_range(0, 3));
    if (r < 19) return letter_t'($urandom_range(0, 25));
    return letter_t'($urandom_range(26, 31));
  endfunction

  function automatic mask_t next_mask();
    case ($urandom_range(0, 9))
      0, 1:    return ALL_LETTERS;
      2, 3:    return ~(mask_t'(1) << $urandom_range(0, 3));
      4, 5:    return mask_t'($urandom);
      6:       return mask_t'($urandom | $urandom | $urandom);
      7:       return mask_t'(1) << $urandom_range(0, 25);
      8:       return mask_t'($urandom_range(0, 15));
      default: return '0;
    endcase
  endfunction

  // One input transfer after a random gap; valid stays high when no gap follows.
  task automatic send_item(func_t kind, letter_t ch, mask_t cls);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, cls, ch};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == FUNC_CLASS) begin
      pat_pos++;
      if (pat_pos >= cur_len) begin
        pat_pos = 0;
        patterns_done++;
      end
    end
  endtask

  // Finishes the pattern in progress, now and then slipping a letter in between.
  task automatic send_pattern();
    bit          loose;
    int unsigned left;
    loose = $urandom_range(0, 1);
    left  = cur_len - pat_pos;
    repeat (left) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(FUNC_LETTER, next_letter(), mask_t'($urandom));
      end
      if (loose) begin
        send_item(FUNC_CLASS, letter_t'($urandom),
                  ($urandom_range(0, 3) == 0) ? ~(mask_t'(1) << $urandom_range(0, 3))
                                              : ALL_LETTERS);
      end else begin
        send_item(FUNC_CLASS, letter_t'($urandom), next_mask());
      end
    end
  endtask

  task automatic send_word();
    repeat (cur_len) send_item(FUNC_LETTER, next_letter(), mask_t'($urandom));
  endtask

  // Length change: drain every result, let the last pattern pass finish, then write.
  task automatic set_word_length(logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (counts_awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = (value == 0) ? 1 : ((value > MAX_LEN) ? MAX_LEN : value);
  endtask

  // Result backpressure: ready runs broken by stalls of random length.
  initial begin : result_backpressure
    int unsigned run;
    int unsigned stall;
    @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    letter_t          first_word [16] = '{5'd25, 5'd0, 5'd31, 5'd26, 5'd1, 5'd2, 5'd3, 5'd4,
                                          5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12};
    logic [CFG_W-1:0] phase_lengths [4] = '{5'd16, 5'd7, 5'd3, 5'd1};
    int unsigned      first_item;
    int unsigned      first_pattern;
    int unsigned      choice;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a length above the maximum, pattern positions on an empty dictionary,
    // a full-length word completed in the middle of a pattern.
    set_word_length(5'd31);
    send_item(FUNC_CLASS, '0, ALL_LETTERS);
    send_item(FUNC_CLASS, 5'd31, '0);
    send_item(FUNC_CLASS, '0, mask_t'($urandom));
    foreach (first_word[i]) send_item(FUNC_LETTER, first_word[i], ALL_LETTERS);
    send_item(FUNC_CLASS, '0, ALL_LETTERS);
    // Shorter length while a pattern is in progress: the next position ends it.
    set_word_length(5'd4);
    send_item(FUNC_CLASS, '0, ALL_LETTERS);
    // Zero length acts as one: every position gives a count.
    set_word_length(5'd0);
    send_item(FUNC_CLASS, '0, ALL_LETTERS);
    send_item(FUNC_CLASS, 5'd25, '0);
    send_item(FUNC_CLASS, '0, mask_t'(1) << 25);
    send_item(FUNC_CLASS, '0, ALL_LETTERS & ~(mask_t'(1) << 25));

    // Random phases at falling lengths, so no pattern reads past a stored word.
    foreach (phase_lengths[p]) begin
      set_word_length(phase_lengths[p]);
      first_item    = items_sent;
      first_pattern = patterns_done;
      while (items_sent - first_item < 20 || patterns_done - first_pattern < 1) begin
        choice = $urandom_range(0, 19);
        if (choice < 9) begin
          send_pattern();
        end else if (choice < 16) begin
          send_word();
        end else begin
          send_item(func_t'($urandom_range(0, 1)), letter_t'($urandom), mask_t'($urandom));
        end
      end
      if (pat_pos != 0) send_pattern();
    end

    // A last run of short patterns at length one.
    repeat (12) send_pattern();

    in_tvalid <= 1'b0;
    do @(negedge clk); while (counts_awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/cpdm_pkg.sv
rtl/class_pattern_dictionary_match_count.sv
sim/match_count_checker.sv
sim/testbench.sv
